FILE: hw/rtl/sha256bc_pkg.sv
package sha256bc_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_SUM,
    S_ROUND,
    S_ADD
  } state_t;

  typedef logic [31:0] word_t;

  localparam int NumRounds = 64;
  localparam int CvWords   = 8;
  localparam int BlockWords = 16;

  localparam logic [2:0] LastDigestIdx = 3'd7;
  localparam logic [3:0] LastWordPos   = 4'd15;
  localparam logic [5:0] LastRound     = 6'd63;

  // standard initial hash value
  localparam logic [CvWords-1:0][31:0] InitValue = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // round constants, entry 0 in the lowest slot
  localparam logic [NumRounds-1:0][31:0] RoundConst = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // schedule sigma functions
  function automatic word_t ssig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // round sigma functions
  function automatic word_t bsig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

FILE: hw/rtl/sha256_block_compression.sv
// channel    | direction | tdata                                | tuser        | tlast
// in_*       | slave     | [31:0] message_word                  | new_message  | final_block
// out_*      | master    | [31:0] digest_word, [34:32] index    | -            | digest_last
//
// words 1 to 15 of a block are taken one per cycle; the 16th starts compression
// rounds 0 to 15 go S_RD_A, S_ROUND; 16 to 63 go S_RD_A, S_RD_B, S_SUM, S_ROUND
// (two read ports, four words), then S_ADD does the chaining add, all with in_tready low
// a final block gives 8 digest transactions, one per cycle while out_tready is high
// the next block's first 15 words are taken while the digest drains
// reset loads the standard initial value and clears word position and output state
module sha256_block_compression (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] message_word
  input  logic        in_tuser,   // [0] new_message
  input  logic        in_tlast,   // final_block
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] digest_index, zero fill
  output logic        out_tlast   // digest_last
);

  sha256bc_pkg::state_t state_r, state_nxt;

  logic [7:0][31:0] cv_r;
  logic [7:0][31:0] v_r;
  logic [7:0][31:0] cv_base;
  logic [3:0]       pos_r;
  logic [5:0]       rnd_r;
  logic             restart_r;
  logic             final_r;
  logic             out_busy_r;
  logic [2:0]       out_idx_r;
  logic [31:0]      x2_r, x7_r, wr_r;

  // schedule memory
  logic [31:0] sched_mem [sha256bc_pkg::BlockWords];
  logic [31:0] rdata0_r, rdata1_r;
  logic [3:0]  rd_addr0, rd_addr1, wr_addr;
  logic        mem_we;
  logic [31:0] mem_wdata;

  logic        in_fire, out_fire;
  logic        early_round;
  logic [31:0] w_cur, w_exp, t1, t2;

  // words are taken only while idle, the 16th waits for the digest to drain
  assign in_tready   = (state_r == sha256bc_pkg::S_IDLE)
                    && !(pos_r == sha256bc_pkg::LastWordPos && out_busy_r);
  assign in_fire     = in_tvalid && in_tready;
  assign out_fire    = out_tvalid && out_tready;
  assign early_round = (rnd_r[5:4] == 2'b00);

  // chaining value a block starts from
  assign cv_base = restart_r ? sha256bc_pkg::InitValue : cv_r;

  // expanded schedule word and round terms
  assign w_exp = sha256bc_pkg::ssig1(x2_r) + x7_r + sha256bc_pkg::ssig0(rdata0_r) + rdata1_r;
  assign w_cur = early_round ? rdata0_r : wr_r;
  assign t1 = v_r[7] + sha256bc_pkg::bsig1(v_r[4])
            + sha256bc_pkg::choose(v_r[4], v_r[5], v_r[6])
            + sha256bc_pkg::RoundConst[rnd_r] + w_cur;
  assign t2 = sha256bc_pkg::bsig0(v_r[0]) + sha256bc_pkg::majority(v_r[0], v_r[1], v_r[2]);

  // sequencer: next state and memory addresses
  always_comb begin
    state_nxt = state_r;
    rd_addr0  = rnd_r[3:0];
    rd_addr1  = rnd_r[3:0] - 4'd7;
    mem_we    = 1'b0;
    wr_addr   = pos_r;
    mem_wdata = in_tdata;
    unique case (state_r)
      sha256bc_pkg::S_IDLE: begin
        mem_we    = in_fire;
        if (in_fire && pos_r == sha256bc_pkg::LastWordPos) begin
          state_nxt = sha256bc_pkg::S_RD_A;
        end
      end
      sha256bc_pkg::S_RD_A: begin
        rd_addr0  = early_round ? rnd_r[3:0] : rnd_r[3:0] - 4'd2;
        state_nxt = early_round ? sha256bc_pkg::S_ROUND : sha256bc_pkg::S_RD_B;
      end
      sha256bc_pkg::S_RD_B: begin
        rd_addr0  = rnd_r[3:0] - 4'd15;
        rd_addr1  = rnd_r[3:0];
        state_nxt = sha256bc_pkg::S_SUM;
      end
      sha256bc_pkg::S_SUM: begin
        mem_we    = 1'b1;
        wr_addr   = rnd_r[3:0];
        mem_wdata = w_exp;
        state_nxt = sha256bc_pkg::S_ROUND;
      end
      sha256bc_pkg::S_ROUND: begin
        state_nxt = (rnd_r == sha256bc_pkg::LastRound) ? sha256bc_pkg::S_ADD
                                                        : sha256bc_pkg::S_RD_A;
      end
      sha256bc_pkg::S_ADD: begin
        state_nxt = sha256bc_pkg::S_IDLE;
      end
      default: begin
        state_nxt = sha256bc_pkg::S_IDLE;
      end
    endcase
  end

  // memory write and registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sched_mem[wr_addr] <= mem_wdata;
    end
    rdata0_r <= sched_mem[rd_addr0];
    rdata1_r <= sched_mem[rd_addr1];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sha256bc_pkg::S_IDLE;
      pos_r      <= '0;
      rnd_r      <= '0;
      restart_r  <= 1'b0;
      final_r    <= 1'b0;
      out_busy_r <= 1'b0;
      out_idx_r  <= '0;
      cv_r       <= sha256bc_pkg::InitValue;
    end else begin
      state_r <= state_nxt;
      // word intake
      if (in_fire) begin
        pos_r <= pos_r + 4'd1;
        if (pos_r == 4'd0) begin
          restart_r <= in_tuser;
        end
        if (pos_r == sha256bc_pkg::LastWordPos) begin
          final_r <= in_tlast;
          rnd_r   <= '0;
        end
      end
      if (state_r == sha256bc_pkg::S_ROUND) begin
        rnd_r <= rnd_r + 6'd1;
      end
      // chaining add and digest launch
      if (state_r == sha256bc_pkg::S_ADD) begin
        for (int k = 0; k < sha256bc_pkg::CvWords; k++) begin
          cv_r[k] <= cv_base[k] + v_r[k];
        end
        restart_r <= 1'b0;
        if (final_r) begin
          out_busy_r <= 1'b1;
          out_idx_r  <= '0;
        end
      end else if (out_fire) begin
        out_idx_r <= out_idx_r + 3'd1;
        if (out_idx_r == sha256bc_pkg::LastDigestIdx) begin
          out_busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == sha256bc_pkg::S_RD_B) begin
      x2_r <= rdata0_r;
      x7_r <= rdata1_r;
    end
    if (state_r == sha256bc_pkg::S_SUM) begin
      wr_r <= w_exp;
    end
    if (in_fire && pos_r == sha256bc_pkg::LastWordPos) begin
      v_r <= cv_base;
    end else if (state_r == sha256bc_pkg::S_ROUND) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  // digest output
  assign out_tvalid = out_busy_r;
  assign out_tdata  = {5'd0, out_idx_r, cv_r[out_idx_r]};
  assign out_tlast  = (out_idx_r == sha256bc_pkg::LastDigestIdx);

  // compression holds off the input
  a_no_intake_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != sha256bc_pkg::S_IDLE |-> !in_tready)
    else $error("input taken during compression");

  // sixteenth word starts round zero
  a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && pos_r == sha256bc_pkg::LastWordPos |=>
      state_r == sha256bc_pkg::S_RD_A && rnd_r == 6'd0)
    else $error("compression did not start at round zero");

  // chaining value holds while a digest drains
  a_cv_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_busy_r && $past(out_busy_r) |-> $stable(cv_r))
    else $error("chaining value changed during digest");

  // a final block launches the digest at word zero
  a_digest_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha256bc_pkg::S_ADD && final_r |=> out_busy_r && out_idx_r == 3'd0)
    else $error("digest not launched");

endmodule

FILE: test/sha256_block_compression_tb.sv
module sha256_block_compression_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         BLOCK_LEN  = 16;
  localparam logic [3:0] FINAL_POS  = 4'd15;
  localparam logic [2:0] LAST_INDEX = 3'd7;
  localparam int         TARGET_WORDS = 310;
  localparam int         CALM_AFTER   = 270;
  localparam int         TAIL_CYCLES  = 300;

  // one directed row: word, restart flag, final flag, digest known up front
  typedef struct packed {
    logic [31:0] word;
    logic        new_msg;
    logic        fin;
    logic        known;
  } stim_row_t;

  // one expected digest transaction
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  localparam logic [31:0] IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // published digest of the three-byte message "abc"
  localparam logic [31:0] ABC_DIGEST [8] = '{
    32'hba7816bf, 32'h8f01cfea, 32'h414140de, 32'h5dae2223,
    32'hb00361a3, 32'h96177a9c, 32'hb410ff61, 32'hf20015ad
  };

  // "abc" block with a stray final flag and a stray restart flag mid-block,
  // then the first words of a block of extreme values
  localparam int NUM_DIRECTED = 25;
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{32'h61626380, 1'b1, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b1, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000018, 1'b0, 1'b1, 1'b1},
    '{32'hffffffff, 1'b1, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'hffffffff, 1'b0, 1'b1, 1'b0},
    '{32'h80000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000001, 1'b0, 1'b0, 1'b0},
    '{32'hffffffff, 1'b1, 1'b0, 1'b0},
    '{32'h7fffffff, 1'b0, 1'b0, 1'b0},
    '{32'hfffffffe, 1'b0, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] message_word
  logic        in_tuser;   // [0] new_message
  logic        in_tlast;   // final_block
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] digest_word, [34:32] digest_index, zero fill
  logic        out_tlast;  // digest_last

  // predictor state
  logic [31:0]  hash_state [8];
  logic [31:0]  msg_sched [BLOCK_LEN];
  logic [3:0]   word_pos;
  digest_beat_t digest_due [$];

  int mismatch_count;
  int words_sent;
  bit calm;

  sha256_block_compression u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  // 64 rounds over the current schedule, folded into the hash state
  task automatic compress_sched();
    logic [31:0] w [BLOCK_LEN];
    logic [31:0] v [8];
    logic [31:0] wr, t1, t2, s0, s1;
    int r;
    for (int k = 0; k < BLOCK_LEN; k++) w[k] = msg_sched[k];
    for (int k = 0; k < 8; k++) v[k] = hash_state[k];
    for (r = 0; r < 64; r++) begin
      if (r < BLOCK_LEN) begin
        wr = w[r];
      end else begin
        s1 = ror32(w[(r - 2) % 16], 17) ^ ror32(w[(r - 2) % 16], 19) ^ (w[(r - 2) % 16] >> 10);
        s0 = ror32(w[(r - 15) % 16], 7) ^ ror32(w[(r - 15) % 16], 18) ^ (w[(r - 15) % 16] >> 3);
        wr = s1 + w[(r - 7) % 16] + s0 + w[r % 16];
        w[r % 16] = wr;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + wr;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int k = 7; k > 0; k--) v[k] = v[k - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int k = 0; k < 8; k++) hash_state[k] = hash_state[k] + v[k];
  endtask

  // update the predictor for one accepted word, queue any digest it produces
  task automatic sha_absorb_word(input logic [31:0] word, input logic new_msg,
                                 input logic fin, input logic known);
    digest_beat_t beat;
    if (word_pos == 4'd0 && new_msg) begin
      for (int k = 0; k < 8; k++) hash_state[k] = IV_WORDS[k];
    end
    msg_sched[word_pos] = word;
    if (word_pos != FINAL_POS) begin
      word_pos = word_pos + 4'd1;
    end else begin
      word_pos = 4'd0;
      compress_sched();
      if (fin) begin
        for (int k = 0; k < 8; k++) begin
          beat.word = known ? ABC_DIGEST[k] : hash_state[k];
          beat.idx  = 3'(k);
          beat.last = (3'(k) == LAST_INDEX);
          digest_due.push_back(beat);
        end
      end
    end
  endtask

  // drive one word, with an optional idle burst ahead of it, until accepted
  task automatic send_word(input logic [31:0] word, input logic new_msg,
                           input logic fin, input logic known);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= new_msg;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sha_absorb_word(word, new_msg, fin, known);
    words_sent++;
    if (words_sent >= CALM_AFTER) calm = 1'b1;
  endtask

  // random word, biased toward extremes and single set bits
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h00000000;
      1:       return 32'hffffffff;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // result side stalls
  initial begin
    forever begin
      if (calm) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // check each digest transaction against the oldest expectation
  always @(posedge clk) begin
    digest_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_due.size() == 0) begin
        $display("%0t: unexpected digest transaction word=%08h index=%0d last=%0b",
                 $time, out_tdata[31:0], out_tdata[34:32], out_tlast);
        mismatch_count++;
      end else begin
        want = digest_due.pop_front();
        if (out_tdata[31:0] !== want.word) begin
          $display("%0t: digest_word expected %08h actual %08h",
                   $time, want.word, out_tdata[31:0]);
          mismatch_count++;
        end
        if (out_tdata[34:32] !== want.idx) begin
          $display("%0t: digest_index expected %0d actual %0d",
                   $time, want.idx, out_tdata[34:32]);
          mismatch_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: digest_last expected %0b actual %0b",
                   $time, want.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic new_msg, fin;
    bit   noisy;
    mismatch_count = 0;
    words_sent     = 0;
    calm           = 1'b0;
    noisy          = 1'b0;
    word_pos       = 4'd0;
    for (int k = 0; k < 8; k++) hash_state[k] = IV_WORDS[k];
    for (int k = 0; k < BLOCK_LEN; k++) msg_sched[k] = '0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_word(DIRECTED[i].word, DIRECTED[i].new_msg, DIRECTED[i].fin, DIRECTED[i].known);
    end

    // mostly well-formed blocks, some with flags scattered at random
    while (words_sent < TARGET_WORDS || word_pos != 4'd0) begin
      if (word_pos == 4'd0) noisy = ($urandom_range(0, 4) == 0);
      if (noisy) begin
        new_msg = 1'($urandom_range(0, 1));
        fin     = 1'($urandom_range(0, 1));
      end else begin
        new_msg = (word_pos == 4'd0) && ($urandom_range(0, 2) != 0);
        fin     = (word_pos == FINAL_POS) && ($urandom_range(0, 1) != 0);
      end
      send_word(pick_word(), new_msg, fin, 1'b0);
    end
    in_tvalid <= 1'b0;

    while (digest_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("timeout with %0d digest transactions outstanding", digest_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sha256_block_compression.f
hw/rtl/sha256bc_pkg.sv
hw/rtl/sha256_block_compression.sv
test/sha256_block_compression_tb.sv
